[sv/ric_pkg.sv]
// ----------------------------------------------------------------------------
// ric_pkg
// Word types, command codes and register offsets for the routed interrupt
// controller.
// ----------------------------------------------------------------------------
package ric_pkg;

  // Command codes
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_LINE  = 2'd2;

  // Register offsets
  localparam logic [5:0] ADDR_ROUTE_LAST = 6'h1f;
  localparam logic [5:0] ADDR_PENDING    = 6'h20;
  localparam logic [5:0] ADDR_ENABLE     = 6'h24;
  localparam logic [5:0] ADDR_ENABLE_SET = 6'h28;
  localparam logic [5:0] ADDR_CLEAR      = 6'h2c;
  localparam logic [5:0] ADDR_POLARITY   = 6'h30;
  localparam logic [5:0] ADDR_EDGE       = 6'h34;
  localparam logic [5:0] ADDR_BCE        = 6'h38;
  localparam logic [5:0] ADDR_AUTO       = 6'h3c;

  // Route byte region and access size limit
  localparam int         RouteBytes = 32;
  localparam logic [2:0] MAX_BYTES  = 3'd4;

  // Route selector codes (route bits 1:0)
  localparam logic [1:0] ROUTE_CPU1 = 2'd2;
  localparam logic [1:0] ROUTE_ALT  = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  addr;
    logic [31:0] wdata;
    logic [2:0]  byte_count;
    logic [4:0]  irq_num;
    logic        line_level;
  } in_word_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic [7:0]  pin_levels;
    logic [31:0] cpu0_status;
    logic [31:0] cpu1_status;
  } out_word_t;

endpackage

[sv/routed_interrupt_controller.sv]
// ----------------------------------------------------------------------------
// routed_interrupt_controller
// Interrupt controller with per-source routing of active sources to two CPUs.
// ----------------------------------------------------------------------------
// Takes one word per cycle unless stalled: a bus read, a bus write or a
// source line change. Each word is captured in an input register and
// processed from there once the output register is free: state is updated
// and the result word is loaded into the output register. The sustained
// rate is one word per clock while out_stall is low. Writes to route bytes
// or defined registers and line changes re-route all active sources
// (pending AND enable) in parallel; route selector 3 alternates a source
// between CPUs on each evaluation, cpu1 first. Route bytes sit at offsets
// 0x00..0x1f, little-endian, with bytes past 0x1f dropped on write and
// read as zero. The output register holds a valid word while out_stall is
// high and the input side stalls only when both registers are occupied.
module routed_interrupt_controller #(
  parameter int NUM_SOURCES = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ric_pkg::in_word_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ric_pkg::out_word_t   out_data
);

  // Handshake
  logic                s1_valid_r;
  ric_pkg::in_word_t   s1_data_r;
  logic                out_valid_r;
  ric_pkg::out_word_t  out_data_r;
  logic                out_free;
  logic                s1_fire;
  logic                in_take;

  // State
  logic [NUM_SOURCES-1:0] pending_r, pending_nxt;
  logic [NUM_SOURCES-1:0] enable_r, enable_nxt;
  logic [NUM_SOURCES-1:0] alt_r, alt_nxt;
  logic [7:0]             route_r   [ric_pkg::RouteBytes];
  logic [7:0]             route_nxt [ric_pkg::RouteBytes];
  logic [31:0]            polarity_r, polarity_nxt;
  logic [31:0]            edge_r, edge_nxt;
  logic [31:0]            bce_r, bce_nxt;
  logic [31:0]            auto_r, auto_nxt;
  logic [7:0]             pins_r, pins_nxt;
  logic [NUM_SOURCES-1:0] cpu0_r, cpu0_nxt;
  logic [NUM_SOURCES-1:0] cpu1_r, cpu1_nxt;

  // Processing
  logic [2:0]             nsat;
  logic                   in_route;
  logic                   do_eval;
  logic [31:0]            rdata;
  logic [31:0]            cpu0_ext;
  logic [31:0]            cpu1_ext;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign nsat     = (s1_data_r.byte_count > ric_pkg::MAX_BYTES) ? ric_pkg::MAX_BYTES
                                                                 : s1_data_r.byte_count;
  assign in_route = (s1_data_r.addr <= ric_pkg::ADDR_ROUTE_LAST);

  // Register writes and line changes
  always_comb begin
    logic [5:0] off;
    pending_nxt  = pending_r;
    enable_nxt   = enable_r;
    polarity_nxt = polarity_r;
    edge_nxt     = edge_r;
    bce_nxt      = bce_r;
    auto_nxt     = auto_r;
    do_eval      = 1'b0;
    off          = '0;
    for (int j = 0; j < ric_pkg::RouteBytes; j++) begin
      route_nxt[j] = route_r[j];
    end
    case (s1_data_r.cmd)
      ric_pkg::CMD_WRITE: begin
        if (in_route) begin
          do_eval = 1'b1;
          for (int j = 0; j < ric_pkg::RouteBytes; j++) begin
            off = 6'(j) - s1_data_r.addr;
            if ((6'(j) >= s1_data_r.addr) && (off < {3'b000, nsat})) begin
              route_nxt[j] = 8'(s1_data_r.wdata >> {off[1:0], 3'b000});
            end
          end
        end else begin
          do_eval = 1'b1;
          case (s1_data_r.addr)
            ric_pkg::ADDR_PENDING:    pending_nxt  = s1_data_r.wdata[NUM_SOURCES-1:0];
            ric_pkg::ADDR_ENABLE:     enable_nxt   = s1_data_r.wdata[NUM_SOURCES-1:0];
            ric_pkg::ADDR_ENABLE_SET: enable_nxt   = enable_r
                                                     | s1_data_r.wdata[NUM_SOURCES-1:0];
            ric_pkg::ADDR_CLEAR: begin
              pending_nxt = pending_r & ~s1_data_r.wdata[NUM_SOURCES-1:0];
              enable_nxt  = enable_r & ~s1_data_r.wdata[NUM_SOURCES-1:0];
            end
            ric_pkg::ADDR_POLARITY:   polarity_nxt = s1_data_r.wdata;
            ric_pkg::ADDR_EDGE:       edge_nxt     = s1_data_r.wdata;
            ric_pkg::ADDR_BCE:        bce_nxt      = s1_data_r.wdata;
            ric_pkg::ADDR_AUTO:       auto_nxt     = s1_data_r.wdata;
            default:                  do_eval      = 1'b0;
          endcase
        end
      end
      ric_pkg::CMD_LINE: begin
        do_eval = 1'b1;
        for (int i = 0; i < NUM_SOURCES; i++) begin
          if (s1_data_r.irq_num == 5'(i)) begin
            pending_nxt[i] = s1_data_r.line_level;
          end
        end
      end
      default: ;
    endcase
  end

  // Routing of all active sources
  always_comb begin
    logic       act;
    logic       cpu;
    logic [7:0] r;
    alt_nxt  = alt_r;
    pins_nxt = pins_r;
    cpu0_nxt = cpu0_r;
    cpu1_nxt = cpu1_r;
    act      = 1'b0;
    cpu      = 1'b0;
    r        = '0;
    if (do_eval) begin
      pins_nxt = '0;
      cpu0_nxt = '0;
      cpu1_nxt = '0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        act = pending_nxt[i] & enable_nxt[i];
        r   = route_nxt[i];
        cpu = 1'b0;
        if (act) begin
          if (r[1:0] == ric_pkg::ROUTE_CPU1) begin
            cpu = 1'b1;
          end else if (r[1:0] == ric_pkg::ROUTE_ALT) begin
            alt_nxt[i] = ~alt_r[i];
            cpu        = ~alt_r[i];
          end
          if (cpu) begin
            pins_nxt[7:4] = pins_nxt[7:4] | r[7:4];
            cpu1_nxt[i]   = 1'b1;
          end else begin
            pins_nxt[3:0] = pins_nxt[3:0] | r[7:4];
            cpu0_nxt[i]   = 1'b1;
          end
        end
      end
    end
  end

  // Bus read data
  always_comb begin
    logic [5:0] idx;
    logic [31:0] act_ext;
    logic [31:0] en_ext;
    rdata   = '0;
    idx     = '0;
    act_ext = '0;
    en_ext  = '0;
    act_ext[NUM_SOURCES-1:0] = pending_r & enable_r;
    en_ext[NUM_SOURCES-1:0]  = enable_r;
    if (s1_data_r.cmd == ric_pkg::CMD_READ) begin
      if (in_route) begin
        for (int k = 0; k < 4; k++) begin
          idx = s1_data_r.addr + 6'(k);
          if ((3'(k) < nsat) && (idx <= ric_pkg::ADDR_ROUTE_LAST)) begin
            rdata[8*k +: 8] = route_r[idx[4:0]];
          end
        end
      end else begin
        case (s1_data_r.addr)
          ric_pkg::ADDR_PENDING:  rdata = act_ext;
          ric_pkg::ADDR_ENABLE:   rdata = en_ext;
          ric_pkg::ADDR_POLARITY: rdata = polarity_r;
          ric_pkg::ADDR_EDGE:     rdata = edge_r;
          ric_pkg::ADDR_BCE:      rdata = bce_r;
          ric_pkg::ADDR_AUTO:     rdata = auto_r;
          default:                rdata = '0;
        endcase
      end
    end
  end

  always_comb begin
    cpu0_ext = '0;
    cpu1_ext = '0;
    cpu0_ext[NUM_SOURCES-1:0] = cpu0_nxt;
    cpu1_ext[NUM_SOURCES-1:0] = cpu1_nxt;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r.rdata       <= rdata;
      out_data_r.pin_levels  <= pins_nxt;
      out_data_r.cpu0_status <= cpu0_ext;
      out_data_r.cpu1_status <= cpu1_ext;
    end
  end

  // Controller state: advance only when the word moves to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= '0;
      enable_r   <= '0;
      alt_r      <= '0;
      polarity_r <= '0;
      edge_r     <= '0;
      bce_r      <= '0;
      auto_r     <= '0;
      pins_r     <= '0;
      cpu0_r     <= '0;
      cpu1_r     <= '0;
      for (int j = 0; j < ric_pkg::RouteBytes; j++) begin
        route_r[j] <= '0;
      end
    end else if (s1_fire) begin
      pending_r  <= pending_nxt;
      enable_r   <= enable_nxt;
      alt_r      <= alt_nxt;
      polarity_r <= polarity_nxt;
      edge_r     <= edge_nxt;
      bce_r      <= bce_nxt;
      auto_r     <= auto_nxt;
      pins_r     <= pins_nxt;
      cpu0_r     <= cpu0_nxt;
      cpu1_r     <= cpu1_nxt;
      for (int j = 0; j < ric_pkg::RouteBytes; j++) begin
        route_r[j] <= route_nxt[j];
      end
    end
  end

endmodule
